>>> rtl/core/kdhr_pkg.sv
package kdhr_pkg;

   // Scan geometry
   localparam int SCAN_SLOTS = 4;
   localparam int KEY_COUNT  = 4;
   localparam int SLOT_W     = 3;

   typedef logic [KEY_COUNT-1:0] mask_type;
   typedef logic [6:0]           code_type;
   typedef logic [7:0]           reg8_type;

   // Key bit assignments (one-hot)
   localparam mask_type BTN_UP    = 4'b0001;
   localparam mask_type BTN_DOWN  = 4'b0010;
   localparam mask_type BTN_RESET = 4'b0100;
   localparam mask_type BTN_ENTER = 4'b1000;
   localparam mask_type BTN_NONE  = 4'b0000;

   // Event codes (ASCII)
   localparam code_type CODE_NONE   = 7'd0;
   localparam code_type CODE_CLEAR  = 7'h63; // c
   localparam code_type CODE_SET    = 7'h73; // s
   localparam code_type CODE_PROG   = 7'h70; // p
   localparam code_type CODE_REL_RS = 7'h6b; // k
   localparam code_type CODE_HLD_RS = 7'h6d; // m
   localparam code_type CODE_REL_EN = 7'h72; // r
   localparam code_type CODE_HLD_EN = 7'h66; // f
   localparam code_type CODE_UP     = 7'h75; // u
   localparam code_type CODE_DOWN   = 7'h64; // d
   localparam code_type CODE_SPACE  = 7'h20; // blank

   // Action codes
   localparam logic ACT_SCAN = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // Control register indexes
   typedef enum logic [1:0] {
      CSR_DEBOUNCE_SCANS = 2'd0,
      CSR_RAMP_START     = 2'd1,
      CSR_RAMP_END       = 2'd2,
      CSR_RAMP_STEP      = 2'd3
   } csr_index_type;

   // Reset values of the control registers
   localparam reg8_type DEBOUNCE_RST   = 8'd3;
   localparam reg8_type RAMP_START_RST = 8'd100;
   localparam reg8_type RAMP_END_RST   = 8'd20;
   localparam reg8_type RAMP_STEP_RST  = 8'd10;

   // One row of the hold table
   typedef struct packed {
      logic     hit;
      code_type release_code;
      code_type hold_code;
      logic     nine_tenths;  // repeat limit is 9/10 of ramp start
      logic     restart;      // reload interval after a hold code
   } hold_entry_type;

   function automatic hold_entry_type hold_lookup(mask_type mask);
      hold_entry_type e;
      e = '{hit: 1'b0, release_code: CODE_NONE, hold_code: CODE_NONE,
            nine_tenths: 1'b0, restart: 1'b0};
      case (mask)
         BTN_RESET: e = '{1'b1, CODE_REL_RS, CODE_HLD_RS, 1'b1, 1'b1};
         BTN_ENTER: e = '{1'b1, CODE_REL_EN, CODE_HLD_EN, 1'b1, 1'b1};
         BTN_UP:    e = '{1'b1, CODE_UP,     CODE_UP,     1'b0, 1'b0};
         BTN_DOWN:  e = '{1'b1, CODE_DOWN,   CODE_DOWN,   1'b0, 1'b0};
         default:   e = '{1'b0, CODE_NONE,   CODE_NONE,   1'b0, 1'b0};
      endcase
      return e;
   endfunction

   // Combination table: CODE_NONE when the mask matches no entry
   function automatic code_type combo_lookup(mask_type mask);
      code_type c;
      c = CODE_NONE;
      case (mask)
         BTN_UP | BTN_RESET:            c = CODE_CLEAR;
         BTN_DOWN | BTN_RESET:          c = CODE_SET;
         BTN_UP | BTN_DOWN | BTN_RESET: c = CODE_PROG;
         default:                       c = CODE_NONE;
      endcase
      return c;
   endfunction

endpackage

>>> rtl/core/keypad_debounce_hold_repeat.sv
// Keypad scanner with debounce, combination codes and accelerating auto-repeat.
// Each scan transaction (action 0) carries one key bit and its sensed line;
// SCAN_SLOTS of them form one full scan, whose key mask must stay stable for
// debounce_scans full scans before it is accepted. Accepted combinations, releases
// and hold/repeat timeouts latch one ASCII event; a read transaction (action 1)
// returns that event on the rsp channel (0 if none) and clears it. Scan
// transactions give no response. One transaction is taken every cycle; the
// item waits in the input register; as it leaves, all state is updated by a
// single pass of logic, which also loads a read's response into the response
// register. The input stalls only while a read waits for
// a stalled response register. Control registers take writes at any time
// (csr_ready is always high) but are only to be changed while the block is idle.
module keypad_debounce_hold_repeat (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  kdhr_pkg::mask_type     req_key_bit,
   input  logic                   req_pressed,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output kdhr_pkg::code_type     rsp_key_code,
   // control register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  kdhr_pkg::csr_index_type csr_index,
   input  kdhr_pkg::reg8_type     csr_data
);
   import kdhr_pkg::*;

   // Control registers
   reg8_type debounce_scans_ff, ramp_start_ff, ramp_end_ff, ramp_step_ff;

   // Input register
   logic     in_valid_ff, in_valid_in;
   logic     in_action_ff;
   mask_type in_key_bit_ff;
   logic     in_pressed_ff;

   // Scanner state
   mask_type gathered_ff, gathered_in;
   mask_type stable_ff, stable_in;
   mask_type accepted_ff, accepted_in;
   code_type last_hold_ff, last_hold_in;
   reg8_type interval_ff, interval_in;
   reg8_type repeat_cnt_ff, repeat_cnt_in;
   reg8_type debounce_cnt_ff, debounce_cnt_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   code_type pending_ff, pending_in;

   // Response register
   logic     rsp_valid_ff, rsp_valid_in;
   code_type rsp_code_ff;

   logic advance;
   logic do_read, do_scan;
   logic accept;

   assign csr_ready = 1'b1;

   // Item leaves the input register unless it is a read and the response is held
   assign advance   = in_valid_ff &&
                      ((in_action_ff == ACT_SCAN) || !rsp_valid_ff || !rsp_stall);
   assign do_read   = advance && (in_action_ff == ACT_READ);
   assign do_scan   = advance && (in_action_ff == ACT_SCAN);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = do_read || (rsp_valid_ff && rsp_stall);

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_key_code = rsp_code_ff;

   // Read clears the pending event; scan: gather, debounce, then the repeat tick
   always_comb begin
      logic [SLOT_W:0] slot_next;
      mask_type        g;
      reg8_type        dc;
      code_type        combo;
      hold_entry_type  rel_e;
      hold_entry_type  hold_e;
      reg8_type        ri;
      logic [11:0]     lhs;
      logic [11:0]     rhs;
      logic            in_limit;

      gathered_in     = gathered_ff;
      stable_in       = stable_ff;
      accepted_in     = accepted_ff;
      last_hold_in    = last_hold_ff;
      interval_in     = interval_ff;
      repeat_cnt_in   = repeat_cnt_ff;
      debounce_cnt_in = debounce_cnt_ff;
      slot_in         = slot_ff;
      pending_in      = pending_ff;

      g         = in_pressed_ff ? (gathered_ff | in_key_bit_ff) : gathered_ff;
      slot_next = {1'b0, slot_ff} + {{SLOT_W{1'b0}}, 1'b1};
      dc        = debounce_cnt_ff;
      combo     = combo_lookup(g);
      rel_e     = hold_lookup(accepted_ff);
      hold_e    = hold_lookup(accepted_ff);
      ri        = interval_ff;
      lhs       = '0;
      rhs       = '0;
      in_limit  = 1'b0;

      if (do_read) begin
         pending_in = CODE_NONE;
      end else if (do_scan) begin
         gathered_in = g;
         // End of a full scan
         if (slot_next >= (SLOT_W+1)'(SCAN_SLOTS)) begin
            slot_in     = '0;
            gathered_in = BTN_NONE;
            stable_in   = g;
            if (g != stable_ff) begin
               dc = debounce_scans_ff;
            end
            debounce_cnt_in = dc;
            if (dc != 8'd0) begin
               debounce_cnt_in = dc - 8'd1;
            end else if (accepted_ff != g) begin
               if (combo != CODE_NONE) begin
                  pending_in = combo;
               end
               // Release to no keys
               if (g == BTN_NONE) begin
                  if (rel_e.hit && (rel_e.hold_code != last_hold_ff)) begin
                     pending_in = rel_e.release_code;
                  end
                  last_hold_in = CODE_SPACE;
               end
               accepted_in   = g;
               repeat_cnt_in = 8'd0;
               interval_in   = ramp_start_ff;
            end
         end else begin
            slot_in = slot_next[SLOT_W-1:0];
         end

         // Repeat tick on the updated state
         hold_e = hold_lookup(accepted_in);
         if (accepted_in != BTN_NONE) begin
            if (repeat_cnt_in < interval_in) begin
               repeat_cnt_in = repeat_cnt_in + 8'd1;
            end else begin
               repeat_cnt_in = 8'd0;
               ri = interval_in;
               if (ri > ramp_end_ff) begin
                  ri = (ri > ramp_step_ff) ? (ri - ramp_step_ff) : 8'd0;
               end
               // ri <= floor(start*9/10) is the same as 10*ri <= 9*start
               lhs = {1'b0, ri, 3'b000} + {3'b000, ri, 1'b0};
               rhs = {1'b0, ramp_start_ff, 3'b000} + {4'b0000, ramp_start_ff};
               in_limit = hold_e.nine_tenths ? (lhs <= rhs) : (ri <= ramp_start_ff);
               interval_in = ri;
               if (hold_e.hit && in_limit) begin
                  last_hold_in = hold_e.hold_code;
                  pending_in   = hold_e.hold_code;
                  if (hold_e.restart) begin
                     interval_in = ramp_start_ff;
                  end
               end
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_scans_ff <= DEBOUNCE_RST;
         ramp_start_ff     <= RAMP_START_RST;
         ramp_end_ff       <= RAMP_END_RST;
         ramp_step_ff      <= RAMP_STEP_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEBOUNCE_SCANS: debounce_scans_ff <= csr_data;
            CSR_RAMP_START:     ramp_start_ff     <= csr_data;
            CSR_RAMP_END:       ramp_end_ff       <= csr_data;
            CSR_RAMP_STEP:      ramp_step_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         gathered_ff     <= BTN_NONE;
         stable_ff       <= BTN_NONE;
         accepted_ff     <= BTN_NONE;
         last_hold_ff    <= CODE_NONE;
         interval_ff     <= 8'd0;
         repeat_cnt_ff   <= 8'd0;
         debounce_cnt_ff <= 8'd0;
         slot_ff         <= '0;
         pending_ff      <= CODE_NONE;
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         gathered_ff     <= gathered_in;
         stable_ff       <= stable_in;
         accepted_ff     <= accepted_in;
         last_hold_ff    <= last_hold_in;
         interval_ff     <= interval_in;
         repeat_cnt_ff   <= repeat_cnt_in;
         debounce_cnt_ff <= debounce_cnt_in;
         slot_ff         <= slot_in;
         pending_ff      <= pending_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_action_ff  <= req_action;
         in_key_bit_ff <= req_key_bit;
         in_pressed_ff <= req_pressed;
      end
      if (do_read) begin
         rsp_code_ff <= pending_ff;
      end
   end

endmodule

>>> tb/keypad_debounce_hold_repeat_tb.sv
`timescale 1ns / 1ps

module keypad_debounce_hold_repeat_tb;
   import kdhr_pkg::*;

   // Clock, reset and block ports
   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic          req_action = ACT_SCAN;
   mask_type      req_key_bit = BTN_NONE;
   logic          req_pressed = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   code_type      rsp_key_code;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_DEBOUNCE_SCANS;
   reg8_type      csr_data = '0;

   keypad_debounce_hold_repeat DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_key_bit  (req_key_bit),
      .req_pressed  (req_pressed),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_key_code (rsp_key_code),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   // Keypad state as the testbench tracks it
   reg8_type cfg_debounce = DEBOUNCE_RST;
   reg8_type cfg_ramp_start = RAMP_START_RST;
   reg8_type cfg_ramp_end = RAMP_END_RST;
   reg8_type cfg_ramp_step = RAMP_STEP_RST;
   mask_type kp_gathered = BTN_NONE;
   mask_type kp_stable = BTN_NONE;
   mask_type kp_accepted = BTN_NONE;
   code_type kp_last_hold = CODE_NONE;
   reg8_type kp_interval = '0;
   reg8_type kp_count = '0;
   reg8_type kp_debounce = '0;
   int       kp_slot = 0;
   code_type kp_latched = CODE_NONE;

   code_type key_codes_due[$];
   int       mismatch_count = 0;
   int       items_sent = 0;
   bit       calm = 1'b0;   // no idling on either side while set

   initial begin
      forever #5 clock = ~clock;
   end

   // Hold table row for one mask; returns 1 on a hit
   function automatic bit hold_row(input mask_type m, output code_type rel,
                                   output code_type hold, output bit nine,
                                   output bit restart);
      rel = CODE_NONE;
      hold = CODE_NONE;
      nine = 1'b0;
      restart = 1'b0;
      case (m)
         BTN_RESET: begin
            rel = CODE_REL_RS; hold = CODE_HLD_RS; nine = 1'b1; restart = 1'b1;
         end
         BTN_ENTER: begin
            rel = CODE_REL_EN; hold = CODE_HLD_EN; nine = 1'b1; restart = 1'b1;
         end
         BTN_UP: begin
            rel = CODE_UP; hold = CODE_UP;
         end
         BTN_DOWN: begin
            rel = CODE_DOWN; hold = CODE_DOWN;
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   // Debounce and acceptance at the end of a full scan
   task automatic close_scan();
      code_type rel, hold;
      bit       nine, restart;
      if (kp_gathered != kp_stable) begin
         kp_debounce = cfg_debounce;
         kp_stable = kp_gathered;
      end
      kp_gathered = BTN_NONE;
      if (kp_debounce != 0) begin
         kp_debounce--;
      end else if (kp_accepted != kp_stable) begin
         case (kp_stable)
            BTN_UP | BTN_RESET:            kp_latched = CODE_CLEAR;
            BTN_DOWN | BTN_RESET:          kp_latched = CODE_SET;
            BTN_UP | BTN_DOWN | BTN_RESET: kp_latched = CODE_PROG;
            default: ;
         endcase
         if (kp_stable == BTN_NONE) begin
            if (hold_row(kp_accepted, rel, hold, nine, restart) && hold != kp_last_hold)
               kp_latched = rel;
            kp_last_hold = CODE_SPACE;
         end
         kp_accepted = kp_stable;
         kp_count = '0;
         kp_interval = cfg_ramp_start;
      end
   endtask

   // Auto-repeat timer, runs on every scan transaction
   task automatic repeat_tick();
      code_type    rel, hold;
      bit          nine, restart;
      int unsigned limit;
      if (kp_accepted == BTN_NONE) return;
      if (kp_count < kp_interval) begin
         kp_count++;
         return;
      end
      kp_count = '0;
      if (kp_interval > cfg_ramp_end)
         kp_interval = (kp_interval > cfg_ramp_step) ? kp_interval - cfg_ramp_step : '0;
      if (hold_row(kp_accepted, rel, hold, nine, restart)) begin
         limit = cfg_ramp_start * (nine ? 9 : 10) / 10;
         if (kp_interval <= limit) begin
            kp_last_hold = hold;
            kp_latched = hold;
            if (restart) kp_interval = cfg_ramp_start;
         end
      end
   endtask

   // Update the tracked keypad for one accepted transaction
   task automatic advance_keypad(input logic act, input mask_type kb, input logic prs);
      if (act == ACT_READ) begin
         key_codes_due.push_back(kp_latched);
         kp_latched = CODE_NONE;
         return;
      end
      if (prs) kp_gathered = kp_gathered | kb;
      if (kp_slot + 1 >= SCAN_SLOTS) begin
         kp_slot = 0;
         close_scan();
      end else begin
         kp_slot = (kp_slot + 1) & 7;
      end
      repeat_tick();
   endtask

   // Send one transaction on the request channel
   task automatic send_item(input logic act, input mask_type kb, input logic prs);
      if (!calm) begin
         while ($urandom_range(99) < 13) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_key_bit <= kb;
      req_pressed <= prs;
      do @(posedge clock); while (req_stall);
      advance_keypad(act, kb, prs);
      items_sent++;
   endtask

   // One full scan with the given keys held; optional bounce and reads
   task automatic send_scan(input mask_type held, input int bounce_pct, input int read_pct);
      logic prs;
      for (int s = 0; s < SCAN_SLOTS; s++) begin
         if ($urandom_range(99) < read_pct)
            send_item(ACT_READ, mask_type'($urandom_range(15)), 1'($urandom_range(1)));
         prs = held[s];
         if ($urandom_range(99) < bounce_pct) prs = ~prs;
         send_item(ACT_SCAN, mask_type'(1) << s, prs);
      end
   endtask

   task automatic read_key();
      send_item(ACT_READ, BTN_NONE, 1'b0);
   endtask

   // Stop sending and let every outstanding read come back
   task automatic settle();
      req_valid <= 1'b0;
      while (key_codes_due.size() > 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input reg8_type val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_DEBOUNCE_SCANS: cfg_debounce = val;
         CSR_RAMP_START:     cfg_ramp_start = val;
         CSR_RAMP_END:       cfg_ramp_end = val;
         CSR_RAMP_STEP:      cfg_ramp_step = val;
         default: ;
      endcase
   endtask

   // Program all four registers back to back
   task automatic program_keypad(input reg8_type deb, input reg8_type rstart,
                                 input reg8_type rend, input reg8_type rstep);
      write_csr(CSR_DEBOUNCE_SCANS, deb);
      write_csr(CSR_RAMP_START, rstart);
      write_csr(CSR_RAMP_END, rend);
      write_csr(CSR_RAMP_STEP, rstep);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // A read with nothing latched, then the program and set combination codes
   task automatic test_combos();
      read_key();
      send_scan(BTN_UP | BTN_DOWN | BTN_RESET, 0, 0);
      read_key();
      send_scan(BTN_DOWN | BTN_RESET, 0, 0);
      read_key();
   endtask

   // Non one-hot key bit merged into the mask in a single slot
   task automatic test_merged_key_bits();
      send_item(ACT_SCAN, BTN_UP | BTN_RESET, 1'b1);
      for (int s = 1; s < SCAN_SLOTS; s++)
         send_item(ACT_SCAN, mask_type'($urandom_range(15)), 1'b0);
      read_key();
   endtask

   // Enter held to a repeat with the interval saturating at zero, then released
   task automatic test_hold_release();
      send_scan(BTN_ENTER, 0, 0);
      read_key();
      send_scan(BTN_NONE, 0, 0);
      read_key();
   endtask

   // Random traffic: mostly held key masks over full scans, some noise
   task automatic test_random_scans(input int n_items, input int max_scans);
      int       start_count;
      int       sent;
      int       nscans;
      mask_type held;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 82) begin
            case ($urandom_range(9))
               0, 1: held = BTN_NONE;
               2: held = BTN_UP;
               3: held = BTN_DOWN;
               4: held = BTN_RESET;
               5: held = BTN_ENTER;
               6: held = BTN_UP | BTN_RESET;
               7: held = BTN_DOWN | BTN_RESET;
               8: held = BTN_UP | BTN_DOWN | BTN_RESET;
               default: held = mask_type'($urandom_range(15));
            endcase
            nscans = $urandom_range(1, max_scans);
            for (int i = 0; i < nscans && sent < n_items; i++) begin
               start_count = items_sent;
               send_scan(held, 4, 12);
               sent += items_sent - start_count;
            end
         end else begin
            repeat ($urandom_range(1, 6)) begin
               send_item(1'($urandom_range(1)), mask_type'($urandom_range(15)),
                         1'($urandom_range(1)));
               sent++;
            end
         end
      end
      settle();
   endtask

   // Main sequence
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero debounce, shortest ramp, step saturating at zero
      program_keypad(8'd0, 8'd1, 8'd0, 8'd255);
      test_combos();
      test_merged_key_bits();
      test_hold_release();
      settle();

      program_keypad(8'd1, 8'd12, 8'd3, 8'd2);
      test_random_scans(500, 12);

      program_keypad(8'd0, 8'd255, 8'd255, 8'd0);
      test_random_scans(400, 80);

      calm = 1'b1;
      program_keypad(8'd2, 8'd6, 8'd0, 8'd1);
      test_random_scans(500, 10);
      calm = 1'b0;

      program_keypad(8'd255, 8'd3, 8'd1, 8'd255);
      test_random_scans(100, 8);

      program_keypad(DEBOUNCE_RST, 8'd20, 8'd5, 8'd5);
      test_random_scans(300, 20);

      if (key_codes_due.size() > 0) mismatch_count++;
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Response stall pattern
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 13);
   end

   // Result checker
   always @(posedge clock) begin
      code_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (key_codes_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: key_code %h", rsp_key_code);
         end else begin
            want = key_codes_due.pop_front();
            if (rsp_key_code !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("key_code mismatch: expected %h, actual %h", want, rsp_key_code);
            end
         end
      end
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
